// ===== hw/rtl/rgbpo_pkg.sv =====
// Shared types, register indexes and per-channel arithmetic for the RGB point-operation unit.
// Depends on nothing; the top level and its checker import it.
package rgbpo_pkg;

  // Widths of the pixel channels and the configuration port.
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned GAIN_W     = 16;

  // Operation codes held in the mode register.
  typedef enum logic [2:0] {
    MODE_BRIGHTNESS = 3'd0,
    MODE_CONTRAST   = 3'd1,
    MODE_GRAYSCALE  = 3'd2,
    MODE_INVERT     = 3'd3,
    MODE_GAIN       = 3'd4,
    MODE_BLEND      = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_BRIGHTNESS = 3'd1,
    REG_CONTRAST   = 3'd2,
    REG_RED_GAIN   = 3'd3,
    REG_GREEN_GAIN = 3'd4,
    REG_BLUE_GAIN  = 3'd5
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET   = 9'sd0;
  localparam logic signed [GAIN_W-1:0]   CONTRAST_RESET = 16'sd256;
  localparam logic [GAIN_W-1:0]          GAIN_RESET     = 16'd256;

  // Luma weights in 0.16 fixed point; they sum to exactly 65536.
  localparam logic [23:0] LUMA_R = 24'd19595;
  localparam logic [23:0] LUMA_G = 24'd38470;
  localparam logic [23:0] LUMA_B = 24'd7471;

  // Mid level and top of the contrast range in Q8.8.
  localparam logic signed [25:0] CONTRAST_MID = 26'sd32768;
  localparam logic signed [25:0] CONTRAST_TOP = 26'sd65280;

  // Add a signed offset and clamp to 0..255.
  function automatic logic [CHAN_W-1:0] brightness_ch(input logic [CHAN_W-1:0] p,
                                                      input logic signed [OFFSET_W-1:0] off);
    logic signed [10:0] s;
    s = $signed({3'b000, p}) + 11'(off);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 11'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  // Scale around mid level 128 in signed Q8.8, clamp, then floor.
  function automatic logic [CHAN_W-1:0] contrast_ch(input logic [CHAN_W-1:0] p,
                                                    input logic signed [GAIN_W-1:0] gain);
    logic signed [8:0]  d;
    logic signed [25:0] v;
    d = $signed({1'b0, p} - 9'd128);
    v = 26'(gain) * 26'(d) + CONTRAST_MID;
    if (v < 0) begin
      return 8'd0;
    end else if (v >= CONTRAST_TOP) begin
      return 8'd255;
    end else begin
      return v[15:8];
    end
  endfunction

  // Weighted luma sum, keeping the integer part.
  function automatic logic [CHAN_W-1:0] luma(input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
    logic [23:0] s;
    s = 24'(r) * LUMA_R + 24'(g) * LUMA_G + 24'(b) * LUMA_B;
    return s[23:16];
  endfunction

  // Unsigned Q8.8 gain with saturation at 255.
  function automatic logic [CHAN_W-1:0] gain_ch(input logic [CHAN_W-1:0] p,
                                                input logic [GAIN_W-1:0] g);
    logic [23:0] prod;
    prod = 24'(p) * 24'(g);
    if (|prod[23:16]) begin
      return 8'd255;
    end else begin
      return prod[15:8];
    end
  endfunction

  // Floored mean of two channels.
  function automatic logic [CHAN_W-1:0] blend_ch(input logic [CHAN_W-1:0] p,
                                                 input logic [CHAN_W-1:0] q);
    logic [8:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[8:1];
  endfunction

endpackage

// ===== hw/rtl/rgb_pixel_point_operations.sv =====
// Top level of the RGB point-operation unit: configuration registers, input register,
// per-channel arithmetic and result register. Depends on rgbpo_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one item: a primary pixel and a
//   second pixel that only the blend mode reads. The result channel
//   (out_valid/out_ready) returns one processed pixel per item, in order.
//   The configuration port writes register cfg_index with cfg_data when cfg_we is
//   high; indexes above 5 are ignored. Write it only while no item is in flight.
//   The edge that accepts an item loads the input register; the result register then
//   loads through the arithmetic once it can take the item, raising out_valid.
//   Throughput is one item per cycle while out_ready stays high; the longest path is
//   one 16x9 contrast multiply plus the clamp compare between the two registers.
//   When the receiver stalls, the result register holds its item and the input
//   register still takes one more item; in_ready drops only when both are full.
//   Synchronous reset empties both registers and loads the register reset values:
//   brightness mode, zero offset and unity gains.
module rgb_pixel_point_operations
  import rgbpo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic [CHAN_W-1:0]     in_second_red,
  input  logic [CHAN_W-1:0]     in_second_green,
  input  logic [CHAN_W-1:0]     in_second_blue,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  mode_t                       mode_r;
  logic signed [OFFSET_W-1:0]  offset_r;
  logic signed [GAIN_W-1:0]    contrast_r;
  logic [GAIN_W-1:0]           red_gain_r;
  logic [GAIN_W-1:0]           green_gain_r;
  logic [GAIN_W-1:0]           blue_gain_r;

  // Input register.
  logic                        in_valid_r;
  logic [CHAN_W-1:0]           red_r;
  logic [CHAN_W-1:0]           green_r;
  logic [CHAN_W-1:0]           blue_r;
  logic [CHAN_W-1:0]           sec_red_r;
  logic [CHAN_W-1:0]           sec_green_r;
  logic [CHAN_W-1:0]           sec_blue_r;

  // Result register.
  logic                        out_valid_r;
  logic [CHAN_W-1:0]           out_red_r;
  logic [CHAN_W-1:0]           out_green_r;
  logic [CHAN_W-1:0]           out_blue_r;
  logic [CHAN_W-1:0]           out_red_nxt;
  logic [CHAN_W-1:0]           out_green_nxt;
  logic [CHAN_W-1:0]           out_blue_nxt;

  logic                        out_load;
  logic                        in_load;
  logic [CHAN_W-1:0]           gray;

  // Configuration writes keep the low bits of each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BRIGHTNESS;
      offset_r     <= OFFSET_RESET;
      contrast_r   <= CONTRAST_RESET;
      red_gain_r   <= GAIN_RESET;
      green_gain_r <= GAIN_RESET;
      blue_gain_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:       mode_r       <= mode_t'(cfg_data[2:0]);
        REG_BRIGHTNESS: offset_r     <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_CONTRAST:   contrast_r   <= $signed(cfg_data);
        REG_RED_GAIN:   red_gain_r   <= cfg_data;
        REG_GREEN_GAIN: green_gain_r <= cfg_data;
        REG_BLUE_GAIN:  blue_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a register loads when it is empty or its successor takes its item.
  assign out_load = !out_valid_r || out_ready;
  assign in_load  = !in_valid_r || out_load;
  assign in_ready = in_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      red_r       <= in_red;
      green_r     <= in_green;
      blue_r      <= in_blue;
      sec_red_r   <= in_second_red;
      sec_green_r <= in_second_green;
      sec_blue_r  <= in_second_blue;
    end
  end

  // Per-channel operation selected by the mode register.
  assign gray = luma(red_r, green_r, blue_r);

  always_comb begin
    case (mode_r)
      MODE_BRIGHTNESS: begin
        out_red_nxt   = brightness_ch(red_r, offset_r);
        out_green_nxt = brightness_ch(green_r, offset_r);
        out_blue_nxt  = brightness_ch(blue_r, offset_r);
      end
      MODE_CONTRAST: begin
        out_red_nxt   = contrast_ch(red_r, contrast_r);
        out_green_nxt = contrast_ch(green_r, contrast_r);
        out_blue_nxt  = contrast_ch(blue_r, contrast_r);
      end
      MODE_GRAYSCALE: begin
        out_red_nxt   = gray;
        out_green_nxt = gray;
        out_blue_nxt  = gray;
      end
      MODE_INVERT: begin
        out_red_nxt   = ~red_r;
        out_green_nxt = ~green_r;
        out_blue_nxt  = ~blue_r;
      end
      MODE_GAIN: begin
        out_red_nxt   = gain_ch(red_r, red_gain_r);
        out_green_nxt = gain_ch(green_r, green_gain_r);
        out_blue_nxt  = gain_ch(blue_r, blue_gain_r);
      end
      MODE_BLEND: begin
        out_red_nxt   = blend_ch(red_r, sec_red_r);
        out_green_nxt = blend_ch(green_r, sec_green_r);
        out_blue_nxt  = blend_ch(blue_r, sec_blue_r);
      end
      default: begin
        // Unused mode codes pass the primary pixel through.
        out_red_nxt   = red_r;
        out_green_nxt = green_r;
        out_blue_nxt  = blue_r;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid_r) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

// ===== hw/rtl/rgbpo_checker.sv =====
// Port-level checks for the RGB point-operation unit, bound to its top level.
// Depends on rgbpo_pkg and on rgb_pixel_point_operations.
module rgbpo_checker
  import rgbpo_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result keeps its item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  // Back-pressure reaches the input only while the result side is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // With the receiver ready, accepted items pass both registers to out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output in two cycles");

endmodule

bind rgb_pixel_point_operations rgbpo_checker u_rgbpo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

// ===== sim/tb_top.sv =====
// Testbench for rgb_pixel_point_operations: directed and random pixels through every mode,
// checked against an in-bench predictor. Depends on rgbpo_pkg and the top-level RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbpo_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned LIMIT_NS     = 6_000_000;

  // Register indexes that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  // Mode codes with no operation assigned; the pixel passes through.
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // Keeps a copy of the registers, predicts each output pixel and compares results in order.
  class pixel_predictor;
    logic [2:0]                  mode_q;
    logic signed [OFFSET_W-1:0]  offset_q;
    logic signed [GAIN_W-1:0]    contrast_q;
    logic [GAIN_W-1:0]           gain_q [3];
    pixel_t                      expected_pixels [$];
    int unsigned                 mismatch_count;

    function new();
      mode_q         = MODE_BRIGHTNESS;
      offset_q       = OFFSET_RESET;
      contrast_q     = CONTRAST_RESET;
      gain_q[0]      = GAIN_RESET;
      gain_q[1]      = GAIN_RESET;
      gain_q[2]      = GAIN_RESET;
      mismatch_count = 0;
    endfunction

    // Only the low bits of each register's width are kept; spare indexes change nothing.
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:       mode_q     = data[2:0];
        REG_BRIGHTNESS: offset_q   = data[OFFSET_W-1:0];
        REG_CONTRAST:   contrast_q = data[GAIN_W-1:0];
        REG_RED_GAIN:   gain_q[0]  = data[GAIN_W-1:0];
        REG_GREEN_GAIN: gain_q[1]  = data[GAIN_W-1:0];
        REG_BLUE_GAIN:  gain_q[2]  = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] clip8(int v);
      if (v < 0) begin
        return 8'd0;
      end
      if (v > 255) begin
        return 8'd255;
      end
      return 8'(v);
    endfunction

    // Signed Q8.8 scaling around 128; everything at or above 255.0 saturates.
    function logic [7:0] contrast_of(logic [7:0] p);
      int v;
      v = int'(contrast_q) * (int'(p) - 128) + 128 * 256;
      if (v < 0) begin
        return 8'd0;
      end
      if (v >= 255 * 256) begin
        return 8'd255;
      end
      return 8'(v >>> 8);
    endfunction

    function logic [7:0] gained(logic [7:0] p, logic [GAIN_W-1:0] g);
      return clip8((int'(p) * int'(g)) >>> 8);
    endfunction

    function pixel_t predict_pixel(pixel_t p, pixel_t q);
      pixel_t r;
      int     y;
      case (mode_q)
        MODE_BRIGHTNESS: begin
          r.red   = clip8(int'(p.red) + int'(offset_q));
          r.green = clip8(int'(p.green) + int'(offset_q));
          r.blue  = clip8(int'(p.blue) + int'(offset_q));
        end
        MODE_CONTRAST: begin
          r.red   = contrast_of(p.red);
          r.green = contrast_of(p.green);
          r.blue  = contrast_of(p.blue);
        end
        MODE_GRAYSCALE: begin
          y = (19595 * int'(p.red) + 38470 * int'(p.green) + 7471 * int'(p.blue)) >>> 16;
          r = '{8'(y), 8'(y), 8'(y)};
        end
        MODE_INVERT: begin
          r = '{~p.red, ~p.green, ~p.blue};
        end
        MODE_GAIN: begin
          r.red   = gained(p.red, gain_q[0]);
          r.green = gained(p.green, gain_q[1]);
          r.blue  = gained(p.blue, gain_q[2]);
        end
        MODE_BLEND: begin
          r.red   = 8'((int'(p.red) + int'(q.red)) >>> 1);
          r.green = 8'((int'(p.green) + int'(q.green)) >>> 1);
          r.blue  = 8'((int'(p.blue) + int'(q.blue)) >>> 1);
        end
        default: begin
          r = p;
        end
      endcase
      return r;
    endfunction

    function void note_pixel(pixel_t p, pixel_t q);
      expected_pixels.push_back(predict_pixel(p, q));
    endfunction

    // One line per mismatch, and the count.
    function void flag_mismatch(string msg);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("result %h with no item outstanding", got));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red) begin
        flag_mismatch($sformatf("out_red %h, expected %h", got.red, want.red));
      end
      if (got.green !== want.green) begin
        flag_mismatch($sformatf("out_green %h, expected %h", got.green, want.green));
      end
      if (got.blue !== want.blue) begin
        flag_mismatch($sformatf("out_blue %h, expected %h", got.blue, want.blue));
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_blue = '0;
  logic [CHAN_W-1:0] in_second_red = '0;
  logic [CHAN_W-1:0] in_second_green = '0;
  logic [CHAN_W-1:0] in_second_blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_predictor px_pred = new();
  int unsigned    results_seen = 0;
  logic           in_valid_seen = 1'b0;

  rgb_pixel_point_operations dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle stretches: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 2);
    end
    if (roll < 96) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] rand_chan();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      return 8'd0;
    end
    if (roll < 12) begin
      return 8'd255;
    end
    if (roll < 16) begin
      return 8'd128;
    end
    return 8'($urandom);
  endfunction

  function automatic pixel_t rand_pixel();
    return '{rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic pixel_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return '{r, g, b};
  endfunction

  // Offers one item after an optional gap and holds it until the block takes it.
  task automatic send_pixel(input pixel_t p, input pixel_t q, input int unsigned gap);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    {in_red, in_green, in_blue} = p;
    {in_second_red, in_second_green, in_second_blue} = q;
    do @(posedge clk); while (!in_ready);
    px_pred.note_pixel(p, q);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    px_pred.set_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering and wait until every item has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (px_pred.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 9'h101;
      1: return 9'h0FF;
      2: return 9'h000;
      3: return 9'h100;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_contrast();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'd256;
      4, 5: return 16'(int'($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd256;
      3, 4: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      px_pred.check_pixel(pixel_t'{out_red, out_green, out_blue});
      results_seen <= results_seen + 1;
    end
    in_valid_seen <= in_valid;
  end

  // Receiver: random stalls, stretches of steady ready, and a long hold-off now and then
  // while the sender is offering, so that both internal registers fill up.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned next_hold_at;
    int unsigned roll;
    hold_left    = 0;
    stall_left   = 0;
    calm_left    = 0;
    next_hold_at = 300;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (results_seen >= next_hold_at && in_valid_seen) begin
        out_ready    = 1'b0;
        hold_left    = 63;
        next_hold_at = next_hold_at + 500;
      end else if (calm_left != 0) begin
        out_ready = 1'b1;
        calm_left--;
      end else if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        roll      = $urandom_range(0, 99);
        if (roll < 4) begin
          calm_left = $urandom_range(20, 80);
        end else if (roll < 40) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    logic [2:0]  mode_code;
    bit          quiet;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: brightness with a zero offset.
    send_pixel(px(0, 0, 0), px(255, 255, 255), 0);
    send_pixel(px(255, 255, 255), px(0, 0, 0), 0);

    // Largest positive offset with junk in the upper bits, then an offset of -255.
    drain();
    write_reg(REG_BRIGHTNESS, 16'hFEFF);
    send_pixel(px(0, 1, 128), px(170, 85, 15), 0);
    drain();
    write_reg(REG_BRIGHTNESS, 16'h0101);
    send_pixel(px(255, 254, 100), px(85, 170, 240), 0);

    // Contrast at unity gain, at both ends of the gain range and at zero gain.
    drain();
    write_reg(REG_MODE, {13'h1FFF, MODE_CONTRAST});
    send_pixel(px(0, 128, 255), px(0, 0, 0), 0);
    drain();
    write_reg(REG_CONTRAST, 16'h7FFF);
    send_pixel(px(127, 128, 129), px(0, 0, 0), 0);
    send_pixel(px(0, 255, 1), px(0, 0, 0), 0);
    drain();
    write_reg(REG_CONTRAST, 16'h8000);
    send_pixel(px(127, 128, 129), px(0, 0, 0), 0);
    drain();
    write_reg(REG_CONTRAST, 16'h0000);
    send_pixel(px(0, 200, 255), px(0, 0, 0), 0);

    // Grayscale: full white must stay at 255.
    drain();
    write_reg(REG_MODE, {13'h0000, MODE_GRAYSCALE});
    send_pixel(px(255, 255, 255), px(0, 0, 0), 0);
    send_pixel(px(0, 0, 0), px(255, 255, 255), 0);
    send_pixel(px(255, 0, 0), px(0, 0, 0), 0);

    // Invert.
    drain();
    write_reg(REG_MODE, {13'h0AAA, MODE_INVERT});
    send_pixel(px(0, 255, 8'h5A), px(0, 0, 0), 0);

    // Channel gain: maximum, zero and unity.
    drain();
    write_reg(REG_MODE, {13'h0000, MODE_GAIN});
    write_reg(REG_RED_GAIN, 16'hFFFF);
    write_reg(REG_GREEN_GAIN, 16'h0000);
    write_reg(REG_BLUE_GAIN, 16'd256);
    send_pixel(px(255, 255, 255), px(0, 0, 0), 0);
    send_pixel(px(1, 128, 7), px(0, 0, 0), 0);

    // Blend.
    drain();
    write_reg(REG_MODE, {13'h1555, MODE_BLEND});
    send_pixel(px(255, 255, 255), px(255, 255, 255), 0);
    send_pixel(px(0, 255, 1), px(1, 0, 0), 0);

    // Spare mode codes pass the pixel through.
    drain();
    write_reg(REG_MODE, {13'h1FFF, MODE_SPARE_6});
    send_pixel(px(12, 34, 56), px(255, 255, 255), 0);
    drain();
    write_reg(REG_MODE, {13'h0000, MODE_SPARE_7});
    send_pixel(px(200, 100, 50), px(0, 0, 0), 0);

    // Writes to the spare indexes must change nothing.
    drain();
    write_reg(REG_UNUSED_6, 16'h0003);
    write_reg(REG_UNUSED_7, 16'h0000);
    send_pixel(px(1, 2, 3), px(4, 5, 6), 0);

    // Random phases: a fresh register setting, then a burst of random pixels.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      mode_code = (phase < 16) ? 3'(phase % 8) : 3'($urandom_range(0, 7));
      write_reg(REG_MODE, {13'($urandom), mode_code});
      write_reg(REG_BRIGHTNESS, {7'($urandom), pick_offset()});
      write_reg(REG_CONTRAST, pick_contrast());
      write_reg(REG_RED_GAIN, pick_gain());
      write_reg(REG_GREEN_GAIN, pick_gain());
      write_reg(REG_BLUE_GAIN, pick_gain());
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 16'($urandom));
      end
      quiet = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(40, 120);
      if (n > RANDOM_ITEMS - sent) begin
        n = RANDOM_ITEMS - sent;
      end
      repeat (n) begin
        send_pixel(rand_pixel(), rand_pixel(), quiet ? 0 : idle_len());
      end
      sent  = sent + n;
      phase = phase + 1;
    end

    drain();
    repeat (10) @(negedge clk);
    if (px_pred.mismatch_count == 0 && px_pred.pending() == 0) begin
      $display("** rgb_pixel_point_operations: PASSED **");
    end else begin
      $display("** rgb_pixel_point_operations: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #LIMIT_NS;
    $display("** rgb_pixel_point_operations: FAILED **");
    $finish;
  end

endmodule

// ===== rgb_pixel_point_operations.f =====
hw/rtl/rgbpo_pkg.sv
hw/rtl/rgb_pixel_point_operations.sv
hw/rtl/rgbpo_checker.sv
sim/tb_top.sv
